FILE: hdl/lfir_pkg.sv
// ----------------------------------------------------------------------------
// lfir_pkg
// Shared constants and types for the linear-phase FIR with edge replication.
// ----------------------------------------------------------------------------
package lfir_pkg;

  localparam int MAX_HALF   = 16;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int COEF_FRAC  = 15;
  localparam int WIN_DEPTH  = 2 * MAX_HALF + 1;
  localparam int SUM_W      = SAMPLE_W + 1;
  localparam int PROD_W     = SUM_W + COEF_W;
  localparam int ACC_W      = PROD_W + 5;
  localparam int Q_W        = ACC_W - COEF_FRAC;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int READ_POS   = MAX_HALF;
  localparam int PRE_LAST   = MAX_HALF;
  localparam int FILL_MAX   = 31;

  localparam logic [1:0] MODE_ODD  = 2'd0;
  localparam logic [1:0] MODE_EVEN = 2'd1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_HALF = 1'b1;

  localparam logic ACT_COEF = 1'b0;

  typedef struct packed {
    logic fill;
    logic shift;
    logic load;
    logic u_sh;
    logic d_sh;
  } win_ctl_t;

endpackage

FILE: hdl/lfir_cell.sv
// ----------------------------------------------------------------------------
// lfir_cell
// One window cell: a stored sample plus an up-running and a down-running copy.
// ----------------------------------------------------------------------------
module lfir_cell (
  input  logic                                clk,
  input  lfir_pkg::win_ctl_t                  ctl,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] s,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] w_prev,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] d_prev,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] u_next,
  output logic signed [lfir_pkg::SAMPLE_W-1:0] w,
  output logic signed [lfir_pkg::SAMPLE_W-1:0] u,
  output logic signed [lfir_pkg::SAMPLE_W-1:0] d
);

  logic signed [lfir_pkg::SAMPLE_W-1:0] w_r, u_r, d_r;

  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      w_r <= s;
    end else if (ctl.shift) begin
      w_r <= w_prev;
    end
    if (ctl.load) begin
      u_r <= w_r;
      d_r <= w_r;
    end else begin
      if (ctl.u_sh) begin
        u_r <= u_next;
      end
      if (ctl.d_sh) begin
        d_r <= d_prev;
      end
    end
  end

  assign w = w_r;
  assign u = u_r;
  assign d = d_r;

endmodule

FILE: hdl/lfir_window.sv
// ----------------------------------------------------------------------------
// lfir_window
// Chain of sample cells; the ends hold so the edge samples replicate.
// ----------------------------------------------------------------------------
module lfir_window (
  input  logic                                clk,
  input  lfir_pkg::win_ctl_t                  ctl,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] s,
  output logic signed [lfir_pkg::SAMPLE_W-1:0] up_tap,
  output logic signed [lfir_pkg::SAMPLE_W-1:0] dn_tap
);

  logic signed [lfir_pkg::SAMPLE_W-1:0] w_a [lfir_pkg::WIN_DEPTH];
  logic signed [lfir_pkg::SAMPLE_W-1:0] u_a [lfir_pkg::WIN_DEPTH];
  logic signed [lfir_pkg::SAMPLE_W-1:0] d_a [lfir_pkg::WIN_DEPTH];

  for (genvar i = 0; i < lfir_pkg::WIN_DEPTH; i++) begin : g_cell
    logic signed [lfir_pkg::SAMPLE_W-1:0] wp, dp, un;
    if (i == 0) begin : g_head
      assign wp = s;
      assign dp = d_a[0];
    end else begin : g_body
      assign wp = w_a[i-1];
      assign dp = d_a[i-1];
    end
    if (i == lfir_pkg::WIN_DEPTH - 1) begin : g_tail
      assign un = u_a[i];
    end else begin : g_mid
      assign un = u_a[i+1];
    end
    lfir_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .s      (s),
      .w_prev (wp),
      .d_prev (dp),
      .u_next (un),
      .w      (w_a[i]),
      .u      (u_a[i]),
      .d      (d_a[i])
    );
  end

  assign up_tap = u_a[0];
  assign dn_tap = d_a[lfir_pkg::READ_POS];

endmodule

FILE: hdl/lfir_mac.sv
// ----------------------------------------------------------------------------
// lfir_mac
// Folded multiply-accumulate with half-up rounding and saturation.
// ----------------------------------------------------------------------------
module lfir_mac (
  input  logic                                 clk,
  input  logic                                 clear,
  input  logic                                 step,
  input  logic                                 sub,
  input  logic                                 zero_b,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] a,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] b,
  input  logic signed [lfir_pkg::COEF_W-1:0]   coef,
  output logic signed [lfir_pkg::SAMPLE_W-1:0] result,
  output logic                                 clip
);

  logic signed [lfir_pkg::SUM_W-1:0]  sa, sb, sum;
  logic signed [lfir_pkg::PROD_W-1:0] prod_r;
  logic                               prod_v_r;
  logic signed [lfir_pkg::ACC_W-1:0]  acc_r, acc_rnd;
  logic signed [lfir_pkg::Q_W-1:0]    q;
  logic signed [lfir_pkg::Q_W-1:0]    q_hi, q_lo;

  always_comb begin
    sa  = lfir_pkg::SUM_W'(a);
    sb  = zero_b ? '0 : lfir_pkg::SUM_W'(b);
    sum = sub ? (sb - sa) : (sb + sa);
  end

  always_ff @(posedge clk) begin
    prod_r <= lfir_pkg::PROD_W'(sum * coef);
    if (clear) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= step;
      if (prod_v_r) begin
        acc_r <= acc_r + lfir_pkg::ACC_W'(prod_r);
      end
    end
  end

  always_comb begin
    acc_rnd = acc_r + (lfir_pkg::ACC_W'(1) <<< (lfir_pkg::COEF_FRAC - 1));
    q       = lfir_pkg::Q_W'(acc_rnd >>> lfir_pkg::COEF_FRAC);
    q_hi    = lfir_pkg::Q_W'((1 <<< (lfir_pkg::SAMPLE_W - 1)) - 1);
    q_lo    = -q_hi - lfir_pkg::Q_W'(1);
    clip    = 1'b0;
    result  = lfir_pkg::SAMPLE_W'(q);
    if (q > q_hi) begin
      result = lfir_pkg::SAMPLE_W'(q_hi);
      clip   = 1'b1;
    end else if (q < q_lo) begin
      result = lfir_pkg::SAMPLE_W'(q_lo);
      clip   = 1'b1;
    end
  end

endmodule

FILE: hdl/linear_phase_fir_edge_replicate.sv
// ----------------------------------------------------------------------------
// linear_phase_fir_edge_replicate
// Folded linear-phase FIR over a chain of sample cells, edge-replicated runs.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | action, coef, sample, last flag
//   out_    | output    | out_valid/out_ready| filtered value, end, clipped
//   cfg     | input     | APB psel/penable   | filter_mode, half_length
//
// A coefficient item is stored on acceptance. A sample item that fills the
// window starts a result (copy load, tap alignment in the cell chain, N shared
// multiply-accumulate steps, drain, push). A flush repeats that per result.
// Synchronous active-low reset clears control; the window needs no clearing.
// A stalled output holds the next result in the push step.
// ----------------------------------------------------------------------------
module linear_phase_fir_edge_replicate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [lfir_pkg::IDX_W-1:0]           in_coef_index,
  input  logic signed [lfir_pkg::COEF_W-1:0]   in_coef_value,
  input  logic signed [lfir_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lfir_pkg::SAMPLE_W-1:0] out_filtered_value,
  output logic                                 out_end_of_run,
  output logic                                 out_clipped,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_PRE, S_MAC, S_DRAIN, S_PUSH} state_t;

  state_t                                state_r;
  logic [1:0]                            mode_r;
  logic [4:0]                            half_r;
  logic [4:0]                            fill_r;
  logic [lfir_pkg::CNT_W-1:0]            cnt_r;
  logic [4:0]                            d_r;
  logic                                  last_r;
  logic signed [lfir_pkg::COEF_W-1:0]    coef_r [lfir_pkg::MAX_HALF];
  logic                                  out_valid_r, end_r, clip_r;
  logic signed [lfir_pkg::SAMPLE_W-1:0]  value_r;

  logic [4:0]                            n_use, look, fill_nxt, p_cnt;
  logic [4:0]                            uoff, doff;
  logic [lfir_pkg::IDX_W-1:0]            cidx;
  lfir_pkg::win_ctl_t                    ctl;
  logic                                  in_acc, smp_acc, push_ok;
  logic signed [lfir_pkg::SAMPLE_W-1:0]  up_tap, dn_tap, mac_res;
  logic                                  mac_clip, mac_clear, mac_step;

  assign pready   = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign smp_acc  = in_acc && (in_action != lfir_pkg::ACT_COEF);
  assign push_ok  = !out_valid_r || out_ready;

  always_comb begin
    n_use = half_r;
    if (half_r == 5'd0) begin
      n_use = 5'd1;
    end else if (half_r > 5'(lfir_pkg::MAX_HALF)) begin
      n_use = 5'(lfir_pkg::MAX_HALF);
    end
    look     = (mode_r == lfir_pkg::MODE_ODD) ? (n_use - 5'd1) : n_use;
    fill_nxt = (fill_r == 5'(lfir_pkg::FILL_MAX)) ? fill_r : (fill_r + 5'd1);
    p_cnt    = (fill_nxt < look + 5'd1) ? fill_nxt : (look + 5'd1);
    uoff     = d_r + (mode_r[1] ? 5'd1 : 5'd0);
    doff     = 5'(lfir_pkg::READ_POS) - d_r
             + ((mode_r == lfir_pkg::MODE_ODD) ? 5'd0 : 5'd1);
    cidx     = lfir_pkg::IDX_W'(n_use - 5'd1 - cnt_r);
  end

  always_comb begin
    ctl.fill  = smp_acc && (fill_r == 5'd0);
    ctl.shift = smp_acc && (fill_r != 5'd0);
    ctl.load  = (state_r == S_LOAD);
    ctl.u_sh  = ((state_r == S_PRE) && (cnt_r < uoff)) || (state_r == S_MAC);
    ctl.d_sh  = ((state_r == S_PRE) && (cnt_r < doff)) || (state_r == S_MAC);
    mac_clear = (state_r == S_LOAD);
    mac_step  = (state_r == S_MAC);
  end

  lfir_window u_window (
    .clk    (clk),
    .ctl    (ctl),
    .s      (in_sample_value),
    .up_tap (up_tap),
    .dn_tap (dn_tap)
  );

  lfir_mac u_mac (
    .clk    (clk),
    .clear  (mac_clear),
    .step   (mac_step),
    .sub    (mode_r[1]),
    .zero_b ((mode_r == lfir_pkg::MODE_ODD) && (cnt_r == '0)),
    .a      (up_tap),
    .b      (dn_tap),
    .coef   (coef_r[cidx]),
    .result (mac_res),
    .clip   (mac_clip)
  );

  always_ff @(posedge clk) begin
    if (in_acc && (in_action == lfir_pkg::ACT_COEF)) begin
      coef_r[in_coef_index] <= in_coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 2'd0;
      half_r      <= 5'd1;
      fill_r      <= 5'd0;
      cnt_r       <= '0;
      d_r         <= 5'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == lfir_pkg::REG_MODE) begin
          mode_r <= pwdata[1:0];
        end else begin
          half_r <= pwdata[4:0];
        end
      end
      if ((state_r == S_PUSH) && push_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (smp_acc) begin
            last_r <= in_last_sample;
            if (in_last_sample) begin
              fill_r  <= 5'd0;
              d_r     <= p_cnt - 5'd1;
              state_r <= S_LOAD;
            end else begin
              fill_r <= fill_nxt;
              if (fill_nxt > look) begin
                d_r     <= look;
                state_r <= S_LOAD;
              end
            end
          end
        end
        S_LOAD: begin
          cnt_r   <= '0;
          state_r <= S_PRE;
        end
        S_PRE: begin
          if (cnt_r == lfir_pkg::CNT_W'(lfir_pkg::PRE_LAST)) begin
            cnt_r   <= '0;
            state_r <= S_MAC;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MAC: begin
          if (cnt_r == n_use - 5'd1) begin
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ok) begin
            value_r <= mac_res;
            clip_r  <= mac_clip;
            end_r   <= last_r && (d_r == 5'd0);
            if (last_r && (d_r != 5'd0)) begin
              d_r     <= d_r - 5'd1;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (paddr[2] == lfir_pkg::REG_HALF) begin
      prdata = {27'd0, half_r};
    end else begin
      prdata = {30'd0, mode_r};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = value_r;
  assign out_end_of_run     = end_r;
  assign out_clipped        = clip_r;

endmodule
